// ===== rtl/mrcs_pkg.sv =====
// shared types, instruction codes and constants of the mips-i core step block
package mrcs_pkg;

   // request opcodes
   localparam logic [1:0] REQ_RUN = 2'd0;
   localparam logic [1:0] REQ_HWR = 2'd1;
   localparam logic [1:0] REQ_HRD = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_EXC = 2'd1;
   localparam logic [1:0] ST_ILL = 2'd2;

   // exception codes
   localparam logic [4:0] EXC_INT  = 5'd0;
   localparam logic [4:0] EXC_ADEL = 5'd4;
   localparam logic [4:0] EXC_ADES = 5'd5;
   localparam logic [4:0] EXC_SYS  = 5'd8;
   localparam logic [4:0] EXC_BP   = 5'd9;
   localparam logic [4:0] EXC_OV   = 5'd12;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_XORI    = 6'h0e;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LWL     = 6'h22;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LWR     = 6'h26;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SWL     = 6'h2a;
   localparam logic [5:0] OP_SW      = 6'h2b;
   localparam logic [5:0] OP_SWR     = 6'h2e;

   // special function codes
   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0c;
   localparam logic [5:0] FN_BREAK   = 6'h0d;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1a;
   localparam logic [5:0] FN_DIVU    = 6'h1b;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2a;
   localparam logic [5:0] FN_SLTU    = 6'h2b;

   // coprocessor 0 forms
   localparam logic [4:0] C0_MF  = 5'h00;
   localparam logic [4:0] C0_MT  = 5'h04;
   localparam logic [4:0] C0_CO  = 5'h10;
   localparam logic [5:0] FN_RFE = 6'h10;

   // coprocessor 0 register numbers
   localparam logic [4:0] C0_BADV  = 5'd8;
   localparam logic [4:0] C0_SR    = 5'd12;
   localparam logic [4:0] C0_CAUSE = 5'd13;
   localparam logic [4:0] C0_EPC   = 5'd14;
   localparam logic [4:0] C0_PRID  = 5'd15;

   // fixed addresses and values
   localparam logic [31:0] RESET_PC    = 32'hbfc00000;
   localparam logic [31:0] HANDLER_BEV = 32'hbfc00180;
   localparam logic [31:0] HANDLER_NRM = 32'h80000080;
   localparam logic [31:0] PRID_RESET  = 32'h00000012;

   // execute outcome classes
   localparam logic [2:0] CLS_DONE  = 3'd0;
   localparam logic [2:0] CLS_LOAD  = 3'd1;
   localparam logic [2:0] CLS_STORE = 3'd2;
   localparam logic [2:0] CLS_MUL   = 3'd3;
   localparam logic [2:0] CLS_DIV   = 3'd4;

   // memory read address select
   localparam logic [1:0] MSEL_PC   = 2'd0;
   localparam logic [1:0] MSEL_HOST = 2'd1;
   localparam logic [1:0] MSEL_A0   = 2'd2;
   localparam logic [1:0] MSEL_A1   = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic       latch;
      logic       irq;
      logic       host_wr;
      logic       dec;
      logic       exec;
      logic       st_wr;
      logic       w0_lat;
      logic       ld_wb;
      logic       mul_fin;
      logic       div_step;
      logic       div_fin;
      logic       hrd;
      logic [1:0] msel;
   } mrcs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic [2:0] cls;
   } mrcs_sts_type;

   // instruction legality
   function automatic logic legal_instr(input logic [31:0] iw);
      logic [5:0] p;
      logic [5:0] f;
      logic [4:0] c;
      logic       ok;
      p  = iw[31:26];
      f  = iw[5:0];
      c  = iw[25:21];
      ok = 1'b0;
      case (p) inside
         OP_SPECIAL: begin
            case (f) inside
               FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
               FN_SYSCALL, FN_BREAK, [FN_MFHI:FN_MTLO], [FN_MULT:FN_DIVU],
               [FN_ADD:FN_NOR], FN_SLT, FN_SLTU: ok = 1'b1;
               default: ok = 1'b0;
            endcase
         end
         [OP_REGIMM:OP_LUI], [OP_LB:OP_LWR], OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR:
            ok = 1'b1;
         OP_COP0: ok = (c == C0_MF) || (c == C0_MT) || ((c == C0_CO) && (f == FN_RFE));
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== rtl/mrcs_ctrl.sv =====
// controller state machine of the mips-i core step block
module mrcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mrcs_pkg::mrcs_sts_type sts,
   output mrcs_pkg::mrcs_cmd_type cmd
);
   import mrcs_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_FETCH = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_MEM0  = 4'd5;
   localparam logic [3:0] S_MEM1  = 4'd6;
   localparam logic [3:0] S_MEM2  = 4'd7;
   localparam logic [3:0] S_MULF  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DIVF  = 4'd10;
   localparam logic [3:0] S_HRD   = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] cls_ff, cls_in;
   logic [4:0] cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      cls_in   = cls_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DISP;
         S_DISP: begin
            unique case (sts.op)
               REQ_RUN: state_in = S_FETCH;
               REQ_HRD: state_in = S_HRD;
               default: state_in = S_RESP;
            endcase
         end
         S_FETCH: state_in = S_DEC;
         S_DEC:   state_in = S_EXEC;
         S_EXEC: begin
            cls_in = sts.cls;
            cnt_in = '0;
            unique case (sts.cls)
               CLS_LOAD, CLS_STORE: state_in = S_MEM0;
               CLS_MUL:             state_in = S_MULF;
               CLS_DIV:             state_in = S_DIV;
               default:             state_in = S_RESP;
            endcase
         end
         S_MEM0: state_in = S_MEM1;
         S_MEM1: state_in = (cls_ff == CLS_STORE) ? S_RESP : S_MEM2;
         S_MEM2: state_in = S_RESP;
         S_MULF: state_in = S_RESP;
         S_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_DIVF;
         end
         S_DIVF: state_in = S_RESP;
         S_HRD:  state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cls_ff   <= CLS_DONE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cls_ff   <= cls_in;
         cnt_ff   <= cnt_in;
      end
   end

   // handshakes and commands
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      cmd          = '0;
      cmd.latch    = (state_ff == S_IDLE) && req_valid;
      cmd.irq      = (state_ff == S_DISP) && (sts.op == REQ_RUN);
      cmd.host_wr  = (state_ff == S_DISP) && (sts.op == REQ_HWR);
      cmd.dec      = (state_ff == S_DEC);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.st_wr    = (state_ff == S_MEM1) && (cls_ff == CLS_STORE);
      cmd.w0_lat   = (state_ff == S_MEM1) && (cls_ff == CLS_LOAD);
      cmd.ld_wb    = (state_ff == S_MEM2);
      cmd.mul_fin  = (state_ff == S_MULF);
      cmd.div_step = (state_ff == S_DIV);
      cmd.div_fin  = (state_ff == S_DIVF);
      cmd.hrd      = (state_ff == S_HRD);
      unique case (state_ff)
         S_DISP:  cmd.msel = MSEL_HOST;
         S_MEM0:  cmd.msel = MSEL_A0;
         S_MEM1:  cmd.msel = MSEL_A1;
         default: cmd.msel = MSEL_PC;
      endcase
   end

   // checks
   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISP))
      else $error("accepted beat did not start dispatch");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped while stalled");
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("block not idle after result beat");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && state_in == S_DIV) |=> (cnt_ff == 5'd0))
      else $error("divide counter not cleared");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides open together");

endmodule

// ===== rtl/mrcs_dpath.sv =====
// datapath of the mips-i core step block: memory, register files, alu, mul and div
module mrcs_dpath #(
   parameter int MEM_WORDS = 16384
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mrcs_pkg::mrcs_cmd_type cmd,
   output mrcs_pkg::mrcs_sts_type sts,
   input  logic [1:0]             req_opcode,
   input  logic                   req_irq_pending,
   input  logic [31:0]            req_host_addr,
   input  logic [31:0]            req_host_data,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_exec_pc,
   output logic [31:0]            rsp_instr_word,
   output logic [4:0]             rsp_cause_code,
   output logic [31:0]            rsp_next_pc,
   output logic [31:0]            rsp_read_data
);
   import mrcs_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   // request beat
   logic [1:0]  op_ff;
   logic        irq_ff;
   logic [31:0] haddr_ff, hdata_ff;

   // architectural state
   logic [31:0] mem_ram [MEM_WORDS];
   logic [31:0] gpr_ram [32];
   logic [31:0] gvld_ff;
   logic [31:0] cop0_ff [32];
   logic [31:0] pc_ff, bt_ff, hi_ff, lo_ff;
   logic        ds_ff;

   // working registers
   logic [31:0] rdata_ff, ir_ff, a_ff, b_ff, addr_ff, w0_ff;
   logic [63:0] prod_ff;
   logic [31:0] rem_ff, quo_ff, den_ff;
   logic        negq_ff, negr_ff;
   logic [1:0]  st_ff;
   logic [31:0] epc_ff, rdat_ff;
   logic [4:0]  code_ff;

   // instruction fields
   logic [5:0]  f_op, f_fn;
   logic [4:0]  f_rs, f_rt, f_rd, f_sa;
   logic [15:0] f_imm;
   logic [31:0] simm, sr, zimm;
   logic [1:0]  lane;
   assign f_op  = ir_ff[31:26];
   assign f_rs  = ir_ff[25:21];
   assign f_rt  = ir_ff[20:16];
   assign f_rd  = ir_ff[15:11];
   assign f_sa  = ir_ff[10:6];
   assign f_fn  = ir_ff[5:0];
   assign f_imm = ir_ff[15:0];
   assign simm  = {{16{f_imm[15]}}, f_imm};
   assign zimm  = {16'h0000, f_imm};
   assign sr    = cop0_ff[C0_SR];
   assign lane  = addr_ff[1:0];

   // execute decode
   logic        ex_legal, ex_gwr, ex_exc, ex_bad_set, ex_br, ex_hi_we, ex_lo_we;
   logic        ex_c0_we, ex_div_start, iso;
   logic [4:0]  ex_gidx, ex_code, ex_c0_idx;
   logic [31:0] ex_gval, ex_bad, ex_bt, ex_hi, ex_lo, ex_c0_val;
   logic [31:0] pc_eff, link, ex_addr, sum, dif, sumi;
   logic [2:0]  ex_cls;

   always_comb begin
      ex_legal     = legal_instr(ir_ff);
      pc_eff       = ds_ff ? (bt_ff - 32'd4) : pc_ff;
      link         = pc_eff + 32'd8;
      ex_addr      = a_ff + simm;
      sum          = a_ff + b_ff;
      dif          = a_ff - b_ff;
      sumi         = a_ff + simm;
      iso          = sr[16];
      ex_gwr       = 1'b0;
      ex_gidx      = f_rd;
      ex_gval      = '0;
      ex_exc       = 1'b0;
      ex_code      = EXC_INT;
      ex_bad_set   = 1'b0;
      ex_bad       = ex_addr;
      ex_br        = 1'b0;
      ex_bt        = pc_eff + 32'd4 + {simm[29:0], 2'b00};
      ex_hi_we     = 1'b0;
      ex_lo_we     = 1'b0;
      ex_hi        = a_ff;
      ex_lo        = a_ff;
      ex_c0_we     = 1'b0;
      ex_c0_idx    = f_rd;
      ex_c0_val    = b_ff;
      ex_div_start = 1'b0;
      ex_cls       = CLS_DONE;
      unique case (f_op)
         OP_SPECIAL: begin
            unique case (f_fn)
               FN_SLL:  begin ex_gwr = 1'b1; ex_gval = b_ff << f_sa; end
               FN_SRL:  begin ex_gwr = 1'b1; ex_gval = b_ff >> f_sa; end
               FN_SRA:  begin ex_gwr = 1'b1; ex_gval = $signed(b_ff) >>> f_sa; end
               FN_SLLV: begin ex_gwr = 1'b1; ex_gval = b_ff << a_ff[4:0]; end
               FN_SRLV: begin ex_gwr = 1'b1; ex_gval = b_ff >> a_ff[4:0]; end
               FN_SRAV: begin ex_gwr = 1'b1; ex_gval = $signed(b_ff) >>> a_ff[4:0]; end
               FN_JR, FN_JALR: begin
                  if (f_fn == FN_JALR) begin
                     ex_gwr  = 1'b1;
                     ex_gval = link;
                  end
                  if (a_ff[1:0] != 2'b00) begin
                     ex_exc     = 1'b1;
                     ex_code    = EXC_ADEL;
                     ex_bad_set = 1'b1;
                     ex_bad     = a_ff;
                  end else begin
                     ex_br = 1'b1;
                     ex_bt = a_ff;
                  end
               end
               FN_SYSCALL: begin ex_exc = 1'b1; ex_code = EXC_SYS; end
               FN_BREAK:   begin ex_exc = 1'b1; ex_code = EXC_BP; end
               FN_MFHI: begin ex_gwr = 1'b1; ex_gval = hi_ff; end
               FN_MTHI: ex_hi_we = 1'b1;
               FN_MFLO: begin ex_gwr = 1'b1; ex_gval = lo_ff; end
               FN_MTLO: ex_lo_we = 1'b1;
               FN_MULT, FN_MULTU: ex_cls = CLS_MUL;
               FN_DIV: begin
                  if (b_ff == 32'd0) begin
                     ex_hi_we = 1'b1;
                     ex_lo_we = 1'b1;
                     ex_lo    = a_ff[31] ? 32'd1 : 32'hffffffff;
                  end else if (a_ff == 32'h80000000 && b_ff == 32'hffffffff) begin
                     ex_hi_we = 1'b1;
                     ex_lo_we = 1'b1;
                     ex_hi    = '0;
                     ex_lo    = 32'h80000000;
                  end else begin
                     ex_div_start = 1'b1;
                     ex_cls       = CLS_DIV;
                  end
               end
               FN_DIVU: begin
                  if (b_ff == 32'd0) begin
                     ex_hi_we = 1'b1;
                     ex_lo_we = 1'b1;
                     ex_lo    = 32'hffffffff;
                  end else begin
                     ex_div_start = 1'b1;
                     ex_cls       = CLS_DIV;
                  end
               end
               FN_ADD: begin
                  if ((~(a_ff[31] ^ b_ff[31])) & (a_ff[31] ^ sum[31])) begin
                     ex_exc  = 1'b1;
                     ex_code = EXC_OV;
                  end else begin
                     ex_gwr  = 1'b1;
                     ex_gval = sum;
                  end
               end
               FN_ADDU: begin ex_gwr = 1'b1; ex_gval = sum; end
               FN_SUB: begin
                  if ((a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ dif[31])) begin
                     ex_exc  = 1'b1;
                     ex_code = EXC_OV;
                  end else begin
                     ex_gwr  = 1'b1;
                     ex_gval = dif;
                  end
               end
               FN_SUBU: begin ex_gwr = 1'b1; ex_gval = dif; end
               FN_AND:  begin ex_gwr = 1'b1; ex_gval = a_ff & b_ff; end
               FN_OR:   begin ex_gwr = 1'b1; ex_gval = a_ff | b_ff; end
               FN_XOR:  begin ex_gwr = 1'b1; ex_gval = a_ff ^ b_ff; end
               FN_NOR:  begin ex_gwr = 1'b1; ex_gval = ~(a_ff | b_ff); end
               FN_SLT: begin
                  ex_gwr  = 1'b1;
                  ex_gval = {31'd0, ($signed(a_ff) < $signed(b_ff))};
               end
               default: begin
                  ex_gwr  = 1'b1;
                  ex_gval = {31'd0, (a_ff < b_ff)};
               end
            endcase
         end
         OP_REGIMM: begin
            if (f_rt[4:1] == 4'b1000) begin
               ex_gwr  = 1'b1;
               ex_gidx = 5'd31;
               ex_gval = link;
            end
            ex_br = f_rt[0] ? !a_ff[31] : a_ff[31];
         end
         OP_J, OP_JAL: begin
            ex_br = 1'b1;
            ex_bt = {pc_eff[31:28], ir_ff[25:0], 2'b00};
            if (f_op == OP_JAL) begin
               ex_gwr  = 1'b1;
               ex_gidx = 5'd31;
               ex_gval = link;
            end
         end
         OP_BEQ:  ex_br = (a_ff == b_ff);
         OP_BNE:  ex_br = (a_ff != b_ff);
         OP_BLEZ: ex_br = (a_ff == 32'd0) || a_ff[31];
         OP_BGTZ: ex_br = (a_ff != 32'd0) && !a_ff[31];
         OP_ADDI: begin
            if ((~(a_ff[31] ^ simm[31])) & (a_ff[31] ^ sumi[31])) begin
               ex_exc  = 1'b1;
               ex_code = EXC_OV;
            end else begin
               ex_gwr  = 1'b1;
               ex_gidx = f_rt;
               ex_gval = sumi;
            end
         end
         OP_ADDIU: begin ex_gwr = 1'b1; ex_gidx = f_rt; ex_gval = sumi; end
         OP_SLTI: begin
            ex_gwr  = 1'b1;
            ex_gidx = f_rt;
            ex_gval = {31'd0, ($signed(a_ff) < $signed(simm))};
         end
         OP_SLTIU: begin
            ex_gwr  = 1'b1;
            ex_gidx = f_rt;
            ex_gval = {31'd0, (a_ff < simm)};
         end
         OP_ANDI: begin ex_gwr = 1'b1; ex_gidx = f_rt; ex_gval = a_ff & zimm; end
         OP_ORI:  begin ex_gwr = 1'b1; ex_gidx = f_rt; ex_gval = a_ff | zimm; end
         OP_XORI: begin ex_gwr = 1'b1; ex_gidx = f_rt; ex_gval = a_ff ^ zimm; end
         OP_LUI:  begin ex_gwr = 1'b1; ex_gidx = f_rt; ex_gval = {f_imm, 16'h0000}; end
         OP_COP0: begin
            if (f_rs == C0_MF) begin
               ex_gwr  = 1'b1;
               ex_gidx = f_rt;
               ex_gval = cop0_ff[f_rd];
            end else if (f_rs == C0_MT) begin
               ex_c0_we = 1'b1;
            end else begin
               // return from exception pops the mode stack
               ex_c0_we  = 1'b1;
               ex_c0_idx = C0_SR;
               ex_c0_val = {sr[31:4], sr[5:2]};
            end
         end
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: if (!iso) ex_cls = CLS_LOAD;
         OP_LWL, OP_LWR: ex_cls = CLS_LOAD;
         OP_SB: if (!iso) ex_cls = CLS_STORE;
         OP_SH: begin
            if (ex_addr[0]) begin
               ex_exc     = 1'b1;
               ex_code    = EXC_ADES;
               ex_bad_set = 1'b1;
            end else if (!iso) begin
               ex_cls = CLS_STORE;
            end
         end
         OP_SW: begin
            if (ex_addr[1:0] != 2'b00) begin
               ex_exc     = 1'b1;
               ex_code    = EXC_ADES;
               ex_bad_set = 1'b1;
            end else if (!iso) begin
               ex_cls = CLS_STORE;
            end
         end
         OP_SWL, OP_SWR: ex_cls = CLS_STORE;
         default: ;
      endcase
      if (!ex_legal) ex_cls = CLS_DONE;
   end

   assign sts.op  = op_ff;
   assign sts.cls = ex_cls;

   // exception entry
   logic        irq_take, xc_fire, xc_ds;
   logic [4:0]  xc_code;
   logic [31:0] xc_pc, cause_pre, xc_cause, xc_sr, handler;

   always_comb begin
      irq_take  = irq_ff && sr[0] && sr[10];
      xc_fire   = (cmd.irq && irq_take) || (cmd.exec && ex_legal && ex_exc);
      xc_ds     = cmd.irq ? ds_ff : 1'b0;
      xc_pc     = cmd.irq ? (ds_ff ? (pc_ff - 32'd4) : pc_ff) : pc_eff;
      xc_code   = cmd.irq ? EXC_INT : ex_code;
      cause_pre = cop0_ff[C0_CAUSE] | ((cmd.irq && irq_ff) ? 32'h00000400 : 32'h0);
      xc_cause  = {xc_ds, cause_pre[30:8], 1'b0, xc_code, 2'b00};
      xc_sr     = {sr[31:6], sr[3:0], 2'b00};
      handler   = sr[22] ? HANDLER_BEV : HANDLER_NRM;
   end

   // store merge and load align
   logic [31:0] st_val, ld_val, r32, w1;
   assign w1 = rdata_ff;

   always_comb begin
      st_val = rdata_ff;
      unique case (f_op)
         OP_SB: st_val[{lane, 3'b000} +: 8] = b_ff[7:0];
         OP_SH: st_val[{lane[1], 4'b0000} +: 16] = b_ff[15:0];
         OP_SWL: begin
            case (lane)
               2'd0:    st_val = {rdata_ff[31:8], b_ff[31:24]};
               2'd1:    st_val = {rdata_ff[31:16], b_ff[31:16]};
               2'd2:    st_val = {rdata_ff[31:24], b_ff[31:8]};
               default: st_val = b_ff;
            endcase
         end
         OP_SWR: begin
            case (lane)
               2'd0:    st_val = b_ff;
               2'd1:    st_val = {b_ff[23:0], rdata_ff[7:0]};
               2'd2:    st_val = {b_ff[15:0], rdata_ff[15:0]};
               default: st_val = {b_ff[7:0], rdata_ff[23:0]};
            endcase
         end
         default: st_val = b_ff;
      endcase
   end

   always_comb begin
      case (lane)
         2'd0:    r32 = w0_ff;
         2'd1:    r32 = {w1[7:0], w0_ff[31:8]};
         2'd2:    r32 = {w1[15:0], w0_ff[31:16]};
         default: r32 = {w1[23:0], w0_ff[31:24]};
      endcase
      unique case (f_op)
         OP_LB:  ld_val = {{24{r32[7]}}, r32[7:0]};
         OP_LH:  ld_val = {{16{r32[15]}}, r32[15:0]};
         OP_LBU: ld_val = {24'd0, r32[7:0]};
         OP_LHU: ld_val = {16'd0, r32[15:0]};
         OP_LWL: begin
            case (lane)
               2'd0:    ld_val = {w0_ff[7:0], b_ff[23:0]};
               2'd1:    ld_val = {w0_ff[15:0], b_ff[15:0]};
               2'd2:    ld_val = {w0_ff[23:0], b_ff[7:0]};
               default: ld_val = w0_ff;
            endcase
         end
         OP_LWR: begin
            case (lane)
               2'd0:    ld_val = w0_ff;
               2'd1:    ld_val = {b_ff[31:24], w0_ff[31:8]};
               2'd2:    ld_val = {b_ff[31:16], w0_ff[31:16]};
               default: ld_val = {b_ff[31:8], w0_ff[31:24]};
            endcase
         end
         default: ld_val = r32;
      endcase
   end

   // main memory, one read and one write port
   logic [AW-1:0] rd_idx, wr_idx, a0_idx;
   logic          mem_we;
   logic [31:0]   mem_wval;
   assign a0_idx = addr_ff[AW+1:2];

   always_comb begin
      case (cmd.msel)
         MSEL_HOST: rd_idx = haddr_ff[AW+1:2];
         MSEL_A0:   rd_idx = a0_idx;
         MSEL_A1:   rd_idx = a0_idx + 1'b1;
         default:   rd_idx = pc_ff[AW+1:2];
      endcase
      mem_we   = cmd.host_wr || cmd.st_wr;
      wr_idx   = cmd.host_wr ? haddr_ff[AW+1:2] : a0_idx;
      mem_wval = cmd.host_wr ? hdata_ff : st_val;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ram[wr_idx] <= mem_wval;
      rdata_ff <= mem_ram[rd_idx];
   end

   // general registers, two registered read ports
   logic       g_we;
   logic [4:0] g_idx, rs_idx, rt_idx;
   logic [31:0] g_val;
   assign rs_idx = rdata_ff[25:21];
   assign rt_idx = rdata_ff[20:16];

   always_comb begin
      if (cmd.ld_wb) begin
         g_idx = f_rt;
         g_val = ld_val;
         g_we  = 1'b1;
      end else begin
         g_idx = ex_gidx;
         g_val = ex_gval;
         g_we  = cmd.exec && ex_legal && ex_gwr;
      end
      g_we = g_we && (g_idx != 5'd0);
   end

   always_ff @(posedge clock) begin
      if (g_we) gpr_ram[g_idx] <= g_val;
      if (cmd.dec) begin
         a_ff <= gvld_ff[rs_idx] ? gpr_ram[rs_idx] : 32'd0;
         b_ff <= gvld_ff[rt_idx] ? gpr_ram[rt_idx] : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) gvld_ff <= '0;
      else if (g_we) gvld_ff[g_idx] <= 1'b1;
   end

   // program counter, branch state and coprocessor 0
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= RESET_PC;
         bt_ff <= '0;
         ds_ff <= 1'b0;
         for (int i = 0; i < 32; i++) cop0_ff[i] <= '0;
         cop0_ff[C0_PRID] <= PRID_RESET;
      end else if (xc_fire) begin
         cop0_ff[C0_CAUSE] <= xc_cause;
         cop0_ff[C0_SR]    <= xc_sr;
         cop0_ff[C0_EPC]   <= xc_pc;
         if (cmd.exec && ex_bad_set) cop0_ff[C0_BADV] <= ex_bad;
         pc_ff <= handler;
         ds_ff <= 1'b0;
      end else if (cmd.irq && irq_ff) begin
         cop0_ff[C0_CAUSE][10] <= 1'b1;
      end else if (cmd.exec && ex_legal) begin
         pc_ff <= pc_eff + 32'd4;
         ds_ff <= ex_br;
         if (ex_br) bt_ff <= ex_bt;
         if (ex_c0_we) cop0_ff[ex_c0_idx] <= ex_c0_val;
      end
   end

   // hi and lo, multiplier and iterative divider
   logic [32:0] div_sh;
   logic [33:0] div_dif;
   logic [31:0] mul_hi;
   logic        mul_sgn;

   always_comb begin
      div_sh  = {rem_ff, quo_ff[31]};
      div_dif = {1'b0, div_sh} - {2'b00, den_ff};
      mul_sgn = (f_fn == FN_MULT);
      mul_hi  = prod_ff[63:32] - ((mul_sgn && a_ff[31]) ? b_ff : 32'd0)
                               - ((mul_sgn && b_ff[31]) ? a_ff : 32'd0);
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_ff * b_ff;
      if (cmd.exec && ex_legal) begin
         if (ex_hi_we) hi_ff <= ex_hi;
         if (ex_lo_we) lo_ff <= ex_lo;
      end
      if (cmd.mul_fin) begin
         hi_ff <= mul_hi;
         lo_ff <= prod_ff[31:0];
      end
      if (cmd.div_fin) begin
         lo_ff <= negq_ff ? (32'd0 - quo_ff) : quo_ff;
         hi_ff <= negr_ff ? (32'd0 - rem_ff) : rem_ff;
      end
      if (cmd.exec && ex_div_start) begin
         rem_ff  <= '0;
         quo_ff  <= (f_fn == FN_DIV && a_ff[31]) ? (32'd0 - a_ff) : a_ff;
         den_ff  <= (f_fn == FN_DIV && b_ff[31]) ? (32'd0 - b_ff) : b_ff;
         negq_ff <= (f_fn == FN_DIV) && (a_ff[31] ^ b_ff[31]);
         negr_ff <= (f_fn == FN_DIV) && a_ff[31];
      end else if (cmd.div_step) begin
         // one restoring step per cycle
         if (!div_dif[33]) begin
            rem_ff <= div_dif[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= div_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   // request beat capture and result fields
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_opcode;
         irq_ff   <= req_irq_pending;
         haddr_ff <= req_host_addr;
         hdata_ff <= req_host_data;
         st_ff    <= ST_OK;
         epc_ff   <= '0;
         ir_ff    <= '0;
         code_ff  <= EXC_INT;
         rdat_ff  <= '0;
      end else begin
         if (xc_fire) begin
            st_ff   <= ST_EXC;
            code_ff <= xc_code;
         end
         if (cmd.exec && !ex_legal) st_ff <= ST_ILL;
         if (cmd.dec) begin
            ir_ff  <= rdata_ff;
            epc_ff <= pc_ff;
         end
         // data address for the memory phases
         if (cmd.exec) addr_ff <= ex_addr;
         if (cmd.w0_lat) w0_ff <= rdata_ff;
         if (cmd.hrd) rdat_ff <= rdata_ff;
      end
   end

   assign rsp_status     = st_ff;
   assign rsp_exec_pc    = epc_ff;
   assign rsp_instr_word = ir_ff;
   assign rsp_cause_code = code_ff;
   assign rsp_next_pc    = pc_ff;
   assign rsp_read_data  = rdat_ff;

endmodule

// ===== rtl/mips_r3000_core_step.sv =====
// top level of the mips-i core step block
//
// One request beat carries an opcode: run one instruction, host write of a
// memory word, or host read of a memory word. Each request gives exactly
// one result beat with status, fetch address, instruction word, exception
// code, program counter after the beat and host read data.
// Both channels use valid/ready; one request is in the block at a time,
// and req_ready is high only while the block is idle.
// The time from request accept to result valid depends on the request kind,
// set by the single memory read port and the controller sequence:
//   run: loads read two memory words, stores read then write memory,
//   isolated loads and stores and faulting stores skip the memory phases,
//   multiplies add a finish step, divides run the restoring divider
//   (one quotient bit per cycle), divides by zero and the overflow case
//   finish at execute like alu, branch, jump and cop0 instructions.
// A new request is taken only after the result beat of the last one
// has been accepted and the block is idle again.
// Reset (synchronous) sets pc to the boot vector, clears the registers and
// branch state; memory contents and hi/lo are undefined until written.
// A stalled result beat holds its fields until rsp_ready.
// MEM_WORDS must be a power of two; the low address bits index memory.
module mips_r3000_core_step #(
   parameter int MEM_WORDS = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic        req_irq_pending,
   input  logic [31:0] req_host_addr,
   input  logic [31:0] req_host_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_exec_pc,
   output logic [31:0] rsp_instr_word,
   output logic [4:0]  rsp_cause_code,
   output logic [31:0] rsp_next_pc,
   output logic [31:0] rsp_read_data
);
   import mrcs_pkg::*;

   mrcs_cmd_type cmd;
   mrcs_sts_type sts;

   // sequencer
   mrcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath and storage
   mrcs_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_irq_pending (req_irq_pending),
      .req_host_addr   (req_host_addr),
      .req_host_data   (req_host_data),
      .rsp_status      (rsp_status),
      .rsp_exec_pc     (rsp_exec_pc),
      .rsp_instr_word  (rsp_instr_word),
      .rsp_cause_code  (rsp_cause_code),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

// ===== dv/mips_r3000_core_step_tb.sv =====
// self-checking testbench for the mips-i core step block
`timescale 1ns / 1ps

module mips_r3000_core_step_tb;
   import mrcs_pkg::*;

   localparam int MEMW = 16384;

   typedef struct {
      logic [1:0]  op;
      logic        irq;
      logic [31:0] addr;
      logic [31:0] data;
   } req_beat_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] exec_pc;
      logic [31:0] instr;
      logic [4:0]  cause;
      logic [31:0] next_pc;
      logic [31:0] rdata;
   } rsp_beat_type;

   localparam logic [5:0] SPECIAL_FNS [28] = '{
      FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
      FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
      FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
      FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
   localparam logic [5:0] MEM_OPS [12] = '{
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH,
      OP_SWL, OP_SW, OP_SWR};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = REQ_HRD;
   logic        req_irq_pending = 1'b0;
   logic [31:0] req_host_addr = '0;
   logic [31:0] req_host_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_exec_pc;
   logic [31:0] rsp_instr_word;
   logic [4:0]  rsp_cause_code;
   logic [31:0] rsp_next_pc;
   logic [31:0] rsp_read_data;

   mips_r3000_core_step dut (.*);

   // architectural copy of the core
   logic [31:0] gpr [32];
   logic [31:0] cp0 [32];
   logic [31:0] hi_val, lo_val, pc, br_target;
   bit          in_slot;
   logic [31:0] mem [MEMW];
   bit          mem_known [MEMW];
   int          known_idx [$];
   bit          hi_known, lo_known;
   logic [4:0]  exc_code;

   req_beat_type pending_reqs [$];
   rsp_beat_type expected_rsps [$];
   req_beat_type drv_beat;
   rsp_beat_type got_beat;
   int        total_reqs;
   int        n_sent;
   int        errors;

   // byte-lane memory access, wrapping modulo memory size
   function automatic logic [31:0] rd8(input logic [31:0] a);
      return (mem[(a >> 2) % MEMW] >> (8 * a[1:0])) & 32'hff;
   endfunction

   function automatic void wr8(input logic [31:0] a, input logic [31:0] v);
      int i;
      i = (a >> 2) % MEMW;
      mem[i] = (mem[i] & ~(32'hff << (8 * a[1:0]))) | ((v & 32'hff) << (8 * a[1:0]));
   endfunction

   function automatic logic [31:0] rd16(input logic [31:0] a);
      return rd8(a) | (rd8(a + 1) << 8);
   endfunction

   function automatic logic [31:0] rd32(input logic [31:0] a);
      return rd16(a) | (rd16(a + 2) << 16);
   endfunction

   function automatic void wr16(input logic [31:0] a, input logic [31:0] v);
      wr8(a, v);
      wr8(a + 1, v >> 8);
   endfunction

   function automatic void wr32(input logic [31:0] a, input logic [31:0] v);
      wr16(a, v);
      wr16(a + 2, v >> 16);
   endfunction

   function automatic void setr(input logic [4:0] r, input logic [31:0] v);
      if (r != 0) gpr[r] = v;
   endfunction

   function automatic bit is_legal(input logic [31:0] iw);
      logic [5:0] p, f;
      logic [4:0] c;
      p = iw[31:26];
      f = iw[5:0];
      c = iw[25:21];
      if (p == OP_SPECIAL) begin
         foreach (SPECIAL_FNS[i]) if (SPECIAL_FNS[i] == f) return 1'b1;
         return 1'b0;
      end
      if (p <= OP_LUI) return 1'b1;
      if (p == OP_COP0) return c == C0_MF || c == C0_MT || (c == C0_CO && f == FN_RFE);
      foreach (MEM_OPS[i]) if (MEM_OPS[i] == p) return 1'b1;
      return 1'b0;
   endfunction

   // exception entry
   function automatic void enter_exc(input logic [4:0] code, input bit setbad,
                                     input logic [31:0] bad);
      logic [31:0] sr;
      sr = cp0[C0_SR];
      cp0[C0_CAUSE][31] = in_slot;
      if (setbad) cp0[C0_BADV] = bad;
      cp0[C0_SR] = {sr[31:6], sr[3:0], 2'b00};
      cp0[C0_CAUSE][7:0] = {1'b0, code, 2'b00};
      cp0[C0_EPC] = pc - (in_slot ? 32'd4 : 32'd0);
      pc = sr[22] ? HANDLER_BEV : HANDLER_NRM;
      in_slot = 1'b0;
      exc_code = code;
   endfunction

   function automatic void take_branch(input bit taken, input logic [31:0] simm);
      if (taken) begin
         br_target = pc + 4 + (simm << 2);
         in_slot = 1'b1;
      end
   endfunction

   // execute one instruction: 0 normal, 1 exception, 2 illegal
   function automatic int exec_instr(input logic [31:0] iw);
      logic [5:0]  p, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] imm, simm, a, b, r, addr, w, sr, an, ad;
      logic signed [63:0] sprod;
      logic [63:0] uprod;
      bit          iso, nn, dn;
      p = iw[31:26];
      fn = iw[5:0];
      rs = iw[25:21];
      rt = iw[20:16];
      rd = iw[15:11];
      sa = iw[10:6];
      imm = {16'h0, iw[15:0]};
      simm = {{16{iw[15]}}, iw[15:0]};
      if (!is_legal(iw)) return 2;
      if (in_slot) begin
         pc = br_target - 4;
         in_slot = 1'b0;
      end
      a = gpr[rs];
      b = gpr[rt];
      addr = a + simm;
      sr = cp0[C0_SR];
      iso = sr[16];
      case (p)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL:  setr(rd, b << sa);
               FN_SRL:  setr(rd, b >> sa);
               FN_SRA:  setr(rd, $signed(b) >>> sa);
               FN_SLLV: setr(rd, b << a[4:0]);
               FN_SRLV: setr(rd, b >> a[4:0]);
               FN_SRAV: setr(rd, $signed(b) >>> a[4:0]);
               FN_JR, FN_JALR: begin
                  if (fn == FN_JALR) setr(rd, pc + 8);
                  if (a[1:0] != 0) begin
                     enter_exc(EXC_ADEL, 1'b1, a);
                     return 1;
                  end
                  br_target = a;
                  in_slot = 1'b1;
               end
               FN_SYSCALL: begin
                  enter_exc(EXC_SYS, 1'b0, 0);
                  return 1;
               end
               FN_BREAK: begin
                  enter_exc(EXC_BP, 1'b0, 0);
                  return 1;
               end
               FN_MFHI: setr(rd, hi_val);
               FN_MTHI: begin hi_val = a; hi_known = 1'b1; end
               FN_MFLO: setr(rd, lo_val);
               FN_MTLO: begin lo_val = a; lo_known = 1'b1; end
               FN_MULT: begin
                  sprod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                  {hi_val, lo_val} = sprod;
                  hi_known = 1'b1;
                  lo_known = 1'b1;
               end
               FN_MULTU: begin
                  uprod = {32'h0, a} * {32'h0, b};
                  {hi_val, lo_val} = uprod;
                  hi_known = 1'b1;
                  lo_known = 1'b1;
               end
               FN_DIV: begin
                  nn = a[31];
                  dn = b[31];
                  an = nn ? -a : a;
                  ad = dn ? -b : b;
                  if (b == 0) begin
                     hi_val = a;
                     lo_val = nn ? 32'd1 : 32'hffffffff;
                  end else if (a == 32'h80000000 && b == 32'hffffffff) begin
                     hi_val = 0;
                     lo_val = 32'h80000000;
                  end else begin
                     lo_val = (nn != dn) ? -(an / ad) : an / ad;
                     hi_val = nn ? -(an % ad) : an % ad;
                  end
                  hi_known = 1'b1;
                  lo_known = 1'b1;
               end
               FN_DIVU: begin
                  if (b == 0) begin
                     hi_val = a;
                     lo_val = 32'hffffffff;
                  end else begin
                     hi_val = a % b;
                     lo_val = a / b;
                  end
                  hi_known = 1'b1;
                  lo_known = 1'b1;
               end
               FN_ADD: begin
                  r = a + b;
                  if ((~(a ^ b) & (a ^ r)) >> 31) begin
                     enter_exc(EXC_OV, 1'b0, 0);
                     return 1;
                  end
                  setr(rd, r);
               end
               FN_ADDU: setr(rd, a + b);
               FN_SUB: begin
                  r = a - b;
                  if (((a ^ b) & (a ^ r)) >> 31) begin
                     enter_exc(EXC_OV, 1'b0, 0);
                     return 1;
                  end
                  setr(rd, r);
               end
               FN_SUBU: setr(rd, a - b);
               FN_AND:  setr(rd, a & b);
               FN_OR:   setr(rd, a | b);
               FN_XOR:  setr(rd, a ^ b);
               FN_NOR:  setr(rd, ~(a | b));
               FN_SLT:  setr(rd, {31'h0, $signed(a) < $signed(b)});
               default: setr(rd, {31'h0, a < b});
            endcase
         end
         OP_REGIMM: begin
            if (iw[20:17] == 4'h8) setr(5'd31, pc + 8);
            take_branch(rt[0] ? !a[31] : a[31], simm);
         end
         OP_J, OP_JAL: begin
            br_target = {pc[31:28], iw[25:0], 2'b00};
            if (p == OP_JAL) setr(5'd31, pc + 8);
            in_slot = 1'b1;
         end
         OP_BEQ:  take_branch(a == b, simm);
         OP_BNE:  take_branch(a != b, simm);
         OP_BLEZ: take_branch(a == 0 || a[31], simm);
         OP_BGTZ: take_branch(a != 0 && !a[31], simm);
         OP_ADDI: begin
            r = a + simm;
            if ((~(a ^ simm) & (a ^ r)) >> 31) begin
               enter_exc(EXC_OV, 1'b0, 0);
               return 1;
            end
            setr(rt, r);
         end
         OP_ADDIU: setr(rt, a + simm);
         OP_SLTI:  setr(rt, {31'h0, $signed(a) < $signed(simm)});
         OP_SLTIU: setr(rt, {31'h0, a < simm});
         OP_ANDI:  setr(rt, a & imm);
         OP_ORI:   setr(rt, a | imm);
         OP_XORI:  setr(rt, a ^ imm);
         OP_LUI:   setr(rt, imm << 16);
         OP_COP0: begin
            if (rs == C0_MF) setr(rt, cp0[rd]);
            else if (rs == C0_MT) cp0[rd] = b;
            else cp0[C0_SR] = {sr[31:4], sr[5:2]};
         end
         OP_LB: if (!iso) begin
            w = rd8(addr);
            setr(rt, {{24{w[7]}}, w[7:0]});
         end
         OP_LH: if (!iso) begin
            w = rd16(addr);
            setr(rt, {{16{w[15]}}, w[15:0]});
         end
         OP_LWL: begin
            w = rd32({addr[31:2], 2'b00});
            case (addr[1:0])
               2'd0: setr(rt, (b & 32'h00ffffff) | (w << 24));
               2'd1: setr(rt, (b & 32'h0000ffff) | (w << 16));
               2'd2: setr(rt, (b & 32'h000000ff) | (w << 8));
               default: setr(rt, w);
            endcase
         end
         OP_LW:  if (!iso) setr(rt, rd32(addr));
         OP_LBU: if (!iso) setr(rt, rd8(addr));
         OP_LHU: if (!iso) setr(rt, rd16(addr));
         OP_LWR: begin
            w = rd32({addr[31:2], 2'b00});
            case (addr[1:0])
               2'd0: setr(rt, w);
               2'd1: setr(rt, (b & 32'hff000000) | (w >> 8));
               2'd2: setr(rt, (b & 32'hffff0000) | (w >> 16));
               default: setr(rt, (b & 32'hffffff00) | (w >> 24));
            endcase
         end
         OP_SB: if (!iso) wr8(addr, b);
         OP_SH: begin
            if (addr[0]) begin
               enter_exc(EXC_ADES, 1'b1, addr);
               return 1;
            end
            if (!iso) wr16(addr, b);
         end
         OP_SWL: begin
            w = rd32({addr[31:2], 2'b00});
            case (addr[1:0])
               2'd0: w = (w & 32'hffffff00) | (b >> 24);
               2'd1: w = (w & 32'hffff0000) | (b >> 16);
               2'd2: w = (w & 32'hff000000) | (b >> 8);
               default: w = b;
            endcase
            wr32({addr[31:2], 2'b00}, w);
         end
         OP_SW: begin
            if (addr[1:0] != 0) begin
               enter_exc(EXC_ADES, 1'b1, addr);
               return 1;
            end
            if (!iso) wr32(addr, b);
         end
         default: begin
            w = rd32({addr[31:2], 2'b00});
            case (addr[1:0])
               2'd0: w = b;
               2'd1: w = (w & 32'h000000ff) | (b << 8);
               2'd2: w = (w & 32'h0000ffff) | (b << 16);
               default: w = (w & 32'h00ffffff) | (b << 24);
            endcase
            wr32({addr[31:2], 2'b00}, w);
         end
      endcase
      pc = pc + 4;
      return 0;
   endfunction

   // predict the result of one request beat, then queue it for the driver
   task automatic send_req(input req_beat_type rq);
      rsp_beat_type e;
      int        rc;
      exc_code = EXC_INT;
      e = '{ST_OK, 32'h0, 32'h0, 5'h0, 32'h0, 32'h0};
      if (rq.op == REQ_RUN) begin
         if (rq.irq) begin
            cp0[C0_CAUSE][10] = 1'b1;
            if (cp0[C0_SR][0] && cp0[C0_SR][10]) begin
               enter_exc(EXC_INT, 1'b0, 0);
               e.status = ST_EXC;
            end
         end
         e.exec_pc = pc;
         e.instr = rd32(pc);
         rc = exec_instr(e.instr);
         if (rc == 2) e.status = ST_ILL;
         else if (rc == 1) e.status = ST_EXC;
      end else if (rq.op == REQ_HWR) begin
         wr32({rq.addr[31:2], 2'b00}, rq.data);
      end else begin
         e.rdata = rd32({rq.addr[31:2], 2'b00});
      end
      e.cause = exc_code;
      e.next_pc = pc;
      expected_rsps.push_back(e);
      pending_reqs.push_back(rq);
   endtask

   // host write of one word, random address bits outside the index
   task automatic host_write(input int idx, input logic [31:0] v);
      logic [31:0] a;
      a = $urandom;
      a[15:2] = 14'(idx);
      send_req('{REQ_HWR, 1'($urandom), a, v});
      if (!mem_known[idx]) known_idx.push_back(idx);
      mem_known[idx] = 1'b1;
   endtask

   // load an instruction at the fetch address and run it, keeping all reads defined
   task automatic run_instr(input logic [31:0] iw_new, input bit fresh, input bit irq);
      logic [31:0] sr, fpc, iw, addr;
      int          fidx, widx;
      sr = cp0[C0_SR];
      fpc = (irq && sr[0] && sr[10]) ? (sr[22] ? HANDLER_BEV : HANDLER_NRM) : pc;
      fidx = fpc[15:2];
      iw = (fresh || !mem_known[fidx]) ? iw_new : mem[fidx];
      if (iw[31:26] == OP_SPECIAL && ((iw[5:0] == FN_MFHI && !hi_known) ||
                                      (iw[5:0] == FN_MFLO && !lo_known)))
         iw[5:0] = FN_MTHI;
      if (!mem_known[fidx] || mem[fidx] != iw) host_write(fidx, iw);
      // data words touched by a load or store
      if (iw[31]) begin
         addr = gpr[iw[25:21]] + {{16{iw[15]}}, iw[15:0]};
         for (int k = 0; k < 2; k++) begin
            widx = ((addr + 3 * k) >> 2) % MEMW;
            if (!mem_known[widx]) host_write(widx, $urandom);
         end
      end
      send_req('{REQ_RUN, irq, $urandom, $urandom});
   endtask

   function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd);
      return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
   endfunction

   function automatic logic [31:0] itype(input logic [5:0] p, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {p, rs, rt, imm};
   endfunction

   // random instruction, weighted toward legal forms
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      int          k;
      k = $urandom_range(0, 99);
      w = $urandom;
      if (k < 30) begin
         w[31:26] = OP_SPECIAL;
         w[5:0] = SPECIAL_FNS[$urandom_range(0, 27)];
      end else if (k < 45) begin
         w[31:26] = 6'($urandom_range(OP_ADDI, OP_LUI));
      end else if (k < 55) begin
         w[31:26] = 6'($urandom_range(OP_REGIMM, OP_BGTZ));
      end else if (k < 75) begin
         w[31:26] = MEM_OPS[$urandom_range(0, 11)];
      end else if (k < 87) begin
         w[31:26] = OP_COP0;
         case ($urandom_range(0, 2))
            0: w[25:21] = C0_MF;
            1: begin
               w[25:21] = C0_MT;
               if ($urandom_range(0, 1)) w[15:11] = C0_SR;
            end
            default: begin
               w[25:21] = C0_CO;
               w[5:0] = FN_RFE;
            end
         endcase
      end else if (k >= 92) begin
         w[31:26] = OP_SPECIAL;
         w[5:0] = 6'($urandom_range(FN_MULT, FN_DIVU));
         if ($urandom_range(0, 3) == 0) w[20:16] = 5'd0;
      end
      return w;
   endfunction

   // response check, one field at a time
   function automatic void check_field(input string nm, input logic [31:0] e,
                                       input logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t %s expected %h actual %h", $time, nm, e, a);
      end
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 &&
             !((n_sent * 4 / total_reqs == 1 && $urandom_range(0, 99) < 51) ||
               (n_sent * 4 / total_reqs == 3 && $urandom_range(0, 99) < 24))) begin
            drv_beat = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_opcode <= drv_beat.op;
            req_irq_pending <= drv_beat.irq;
            req_host_addr <= drv_beat.addr;
            req_host_data <= drv_beat.data;
            n_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !((n_sent * 4 / total_reqs == 2 && $urandom_range(0, 99) < 51) ||
                        (n_sent * 4 / total_reqs == 3 && $urandom_range(0, 99) < 24));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t unexpected beat expected none actual pc %h", $time, rsp_exec_pc);
         end else begin
            got_beat = expected_rsps.pop_front();
            check_field("status", got_beat.status, rsp_status);
            check_field("exec_pc", got_beat.exec_pc, rsp_exec_pc);
            check_field("instr_word", got_beat.instr, rsp_instr_word);
            check_field("cause_code", got_beat.cause, rsp_cause_code);
            check_field("next_pc", got_beat.next_pc, rsp_next_pc);
            check_field("read_data", got_beat.rdata, rsp_read_data);
         end
      end
   end

   // run limit
   initial begin
      #20_000_000;
      $display("[mips_r3000_core_step] ERROR");
      $finish;
   end

   // stimulus and end of run
   initial begin
      foreach (gpr[i]) begin
         gpr[i] = 0;
         cp0[i] = 0;
      end
      cp0[C0_PRID] = PRID_RESET;
      hi_val = 0;
      lo_val = 0;
      pc = RESET_PC;
      br_target = 0;
      in_slot = 1'b0;
      n_sent = 0;
      errors = 0;
      total_reqs = 1;

      // directed: host extremes
      send_req('{REQ_HWR, 1'b1, 32'hffffffff, 32'hffffffff});
      mem_known[MEMW - 1] = 1'b1;
      known_idx.push_back(MEMW - 1);
      send_req('{REQ_HWR, 1'b0, 32'h00000000, 32'h00000000});
      mem_known[0] = 1'b1;
      known_idx.push_back(0);
      send_req('{REQ_HRD, 1'b0, 32'hfffffffc, 32'hffffffff});
      send_req('{REQ_HRD, 1'b1, 32'h00000003, 32'h0});
      // directed: divide corners, overflow, traps, illegal forms
      run_instr(itype(OP_LUI, 0, 1, 16'h8000), 1, 0);
      run_instr(itype(OP_ADDIU, 0, 2, 16'hffff), 1, 0);
      run_instr(rtype(FN_DIV, 1, 2, 0), 1, 0);
      run_instr(rtype(FN_MFLO, 0, 0, 3), 1, 0);
      run_instr(rtype(FN_DIV, 1, 0, 0), 1, 0);
      run_instr(rtype(FN_DIVU, 2, 0, 0), 1, 0);
      run_instr(rtype(FN_MFHI, 0, 0, 4), 1, 0);
      run_instr(rtype(FN_MULT, 1, 2, 0), 1, 0);
      run_instr(rtype(FN_ADD, 1, 1, 5), 1, 0);
      run_instr(rtype(FN_SYSCALL, 0, 0, 0), 1, 0);
      run_instr(rtype(FN_BREAK, 0, 0, 0), 1, 0);
      run_instr(32'hfc000000, 1, 0);
      run_instr({OP_COP0, 5'h08, 21'h0}, 1, 0);
      // directed: interrupt with boot vectors, then return from exception
      run_instr(itype(OP_LUI, 0, 6, 16'h0040), 1, 0);
      run_instr(itype(OP_ORI, 6, 6, 16'h0401), 1, 0);
      run_instr({OP_COP0, C0_MT, 5'd6, C0_SR, 11'h0}, 1, 0);
      run_instr(itype(OP_ADDIU, 0, 9, 16'h0001), 1, 1);
      run_instr({OP_COP0, C0_CO, 15'h0, FN_RFE}, 1, 0);
      // directed: unaligned forms and address errors
      run_instr(itype(OP_LWL, 2, 7, 16'h0003), 1, 0);
      run_instr(itype(OP_LWR, 2, 7, 16'h0000), 1, 0);
      run_instr(itype(OP_SWL, 2, 2, 16'h0001), 1, 0);
      run_instr(itype(OP_SWR, 2, 2, 16'h0002), 1, 0);
      run_instr(itype(OP_SH, 0, 2, 16'h0001), 1, 0);
      run_instr(itype(OP_SW, 0, 2, 16'h0002), 1, 0);
      run_instr(rtype(FN_JR, 2, 0, 0), 1, 0);
      // directed: taken branch and its delay slot, then an isolated load
      run_instr(itype(OP_BEQ, 0, 0, 16'h0004), 1, 0);
      run_instr(itype(OP_ADDIU, 0, 8, 16'h0001), 1, 0);
      run_instr(itype(OP_LUI, 0, 7, 16'h0001), 1, 0);
      run_instr({OP_COP0, C0_MT, 5'd7, C0_SR, 11'h0}, 1, 0);
      run_instr(itype(OP_LB, 0, 8, 16'h0000), 1, 0);

      // random programs with some host traffic mixed in
      while (pending_reqs.size() < 1600) begin
         case ($urandom_range(0, 99)) inside
            [0:5]: send_req('{REQ_HRD, 1'($urandom),
                              {$urandom_range(0, 65535), 16'h0} |
                              (known_idx[$urandom_range(0, known_idx.size() - 1)] << 2) |
                              $urandom_range(0, 3),
                              $urandom});
            [6:9]: host_write($urandom_range(0, MEMW - 1), $urandom);
            default: run_instr(rand_instr(), $urandom_range(0, 7) != 0,
                               $urandom_range(0, 99) < 30);
         endcase
      end
      total_reqs = pending_reqs.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("[mips_r3000_core_step] OK");
      else
         $display("[mips_r3000_core_step] ERROR");
      $finish;
   end

endmodule
